// ===== rtl/equi_width_key_histogram_defines.svh =====
// assertion macros for the histogram block
`ifndef EQUI_WIDTH_KEY_HISTOGRAM_DEFINES_SVH
`define EQUI_WIDTH_KEY_HISTOGRAM_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EWKH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EWKH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EWKH_ASSERT(lbl, prop, msg)
`define EWKH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/ewkh_pkg.sv =====
`timescale 1ns / 1ps
package ewkh_pkg;

  localparam int KEY_W  = 32;
  localparam int SPAN_W = 33;
  localparam int OCNT_W = 24;
  localparam int ONE_W  = 7;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_KEYQ   = 2'd2;
  localparam logic [1:0] KIND_RANGEQ = 2'd3;

  localparam logic CFG_MIN_KEY = 1'b0;
  localparam logic CFG_MAX_KEY = 1'b1;

  typedef logic [OCNT_W-1:0] ocnt_t;

  function automatic ocnt_t clamp_cnt(input logic [63:0] v);
    clamp_cnt = (v > 64'hFF_FFFF) ? '1 : v[OCNT_W-1:0];
  endfunction

  function automatic logic [ONE_W-1:0] clamp_ne(input logic [63:0] v);
    clamp_ne = (v > 64'd127) ? '1 : v[ONE_W-1:0];
  endfunction

endpackage

// ===== rtl/equi_width_key_histogram.sv =====
`timescale 1ns / 1ps
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready   | tuser: kind; tdata: key, range_end
// out     | out | out_tvalid/out_tready | tuser: in_range; tdata: stats
// cfg     | in  | cfg_valid/cfg_ready   | cfg_addr: register, cfg_data: value
// one request at a time; bucket search uses a shared restoring divider, one quotient
// bit a cycle for log2(BUCKETS) steps; edges are a shift (BUCKETS a power of two)
// insert/key query then finds both edges; range query sums its buckets one by one,
// clear sweeps all buckets, an out-of-range key skips the search; stall in S_OUT only
// after rst_n the bucket memory is swept to zero with in_tready low
`include "equi_width_key_histogram_defines.svh"
module equi_width_key_histogram #(
  parameter int BUCKETS     = 64,
  parameter int COUNT_WIDTH = 24
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // [1:0] kind
  input  logic [63:0]  in_tdata,   // [31:0] key, [63:32] range_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [0:0]   out_tuser,  // [0] in_range
  output logic [111:0] out_tdata,  // count, distinct_values, bucket_width,
                                   // total_keys, nonempty_buckets
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_data
);

  localparam int AW = $clog2(BUCKETS);
  localparam int IW = $clog2(BUCKETS + 1);
  localparam int SW = ewkh_pkg::SPAN_W;
  localparam int NW = SW + IW;
  localparam int CW = COUNT_WIDTH;
  localparam bit BKT_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PREP = 4'd2;
  localparam logic [3:0] S_LOAD = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_DONE = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] PH_KEYB = 2'd0;
  localparam logic [1:0] PH_ENDB = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;
  localparam logic [1:0] PH_HI   = 2'd3;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic clr_item_r, clr_item_nxt;
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [IW-1:0] occ_r, occ_nxt;
  logic signed [31:0] min_key_r, min_key_nxt, max_key_r, max_key_nxt;

  logic [1:0] kind_r, kind_nxt;
  logic signed [31:0] key_r, key_nxt, end_r, end_nxt;
  logic [AW-1:0] b_r, b_nxt, e_r, e_nxt;
  logic [NW-1:0] prod_r, prod_nxt, num_r, num_nxt;
  logic [SW-1:0] rem_r, rem_nxt, q_r, q_nxt, lo_r, lo_nxt;
  logic [5:0] step_r, step_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  ewkh_pkg::ocnt_t acc_r, acc_nxt;
  logic res_hit_r, res_hit_nxt;
  ewkh_pkg::ocnt_t res_cnt_r, res_cnt_nxt, res_dist_r, res_dist_nxt;
  logic [SW-1:0] res_wid_r, res_wid_nxt;
  logic out_hit_r, out_hit_nxt;
  ewkh_pkg::ocnt_t out_cnt_r, out_cnt_nxt, out_dist_r, out_dist_nxt;
  ewkh_pkg::ocnt_t out_tot_r, out_tot_nxt;
  logic [SW-1:0] out_wid_r, out_wid_nxt;
  logic [ewkh_pkg::ONE_W-1:0] out_ne_r, out_ne_nxt;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  logic range_ok, key_in, end_in, bucket_mode, ge;
  logic [SW-1:0] span, divisor, d_p1, wid;
  logic signed [31:0] op;
  logic [IW-1:0] idx;
  logic [NW-1:0] prod_c;
  logic [SW:0] trial, diff;
  logic [CW-1:0] c_new;
  logic [ewkh_pkg::OCNT_W:0] acc_sum;

  ewkh_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign range_ok = max_key_r >= min_key_r;
  assign span = SW'({max_key_r[31], max_key_r} - {min_key_r[31], min_key_r}) + SW'(1);
  assign key_in = range_ok && ($signed(in_tdata[31:0]) >= min_key_r)
                  && ($signed(in_tdata[31:0]) <= max_key_r);
  assign end_in = range_ok && (end_r >= min_key_r) && (end_r <= max_key_r);
  assign bucket_mode = (phase_r == PH_KEYB) || (phase_r == PH_ENDB);
  assign op = (phase_r == PH_ENDB) ? end_r : key_r;
  assign d_p1 = SW'({op[31], op} - {min_key_r[31], min_key_r}) + SW'(1);
  assign idx = (phase_r == PH_LO) ? IW'(b_r) : IW'(b_r) + IW'(1);
  assign prod_c = bucket_mode ? (NW'(d_p1) * NW'(BUCKETS) - NW'(1))
                              : (NW'(idx) * NW'(span));
  assign divisor = bucket_mode ? span : SW'(BUCKETS);
  assign trial = {rem_r, num_r[NW-1]};
  assign ge = trial >= {1'b0, divisor};
  assign diff = trial - {1'b0, divisor};
  assign wid = q_r - lo_r;
  assign c_new = (kind_r == ewkh_pkg::KIND_INSERT && ram_rdata != '1)
                 ? ram_rdata + CW'(1) : ram_rdata;
  assign acc_sum = {1'b0, acc_r} + {1'b0, ewkh_pkg::clamp_cnt(64'(ram_rdata))};

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser = out_hit_r;
  assign out_tdata = {out_ne_r, out_tot_r, out_wid_r, out_dist_r, out_cnt_r};

  always_comb begin
    state_nxt = state_r;     phase_nxt = phase_r;     i_nxt = i_r;
    clr_item_nxt = clr_item_r; pend_nxt = pend_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    total_nxt = total_r;     occ_nxt = occ_r;
    min_key_nxt = min_key_r; max_key_nxt = max_key_r;
    kind_nxt = kind_r;       key_nxt = key_r;         end_nxt = end_r;
    b_nxt = b_r;             e_nxt = e_r;             prod_nxt = prod_r;
    num_nxt = num_r;         rem_nxt = rem_r;         q_nxt = q_r;
    lo_nxt = lo_r;           step_nxt = step_r;       cnt_nxt = cnt_r;
    acc_nxt = acc_r;         res_hit_nxt = res_hit_r; res_cnt_nxt = res_cnt_r;
    res_dist_nxt = res_dist_r; res_wid_nxt = res_wid_r;
    out_hit_nxt = out_hit_r; out_cnt_nxt = out_cnt_r; out_dist_nxt = out_dist_r;
    out_tot_nxt = out_tot_r; out_wid_nxt = out_wid_r; out_ne_nxt = out_ne_r;
    ram_we = 1'b0;
    ram_waddr = i_r[AW-1:0];
    ram_wdata = '0;
    ram_raddr = b_r;

    if (cfg_valid) begin
      if (cfg_addr == ewkh_pkg::CFG_MIN_KEY) begin
        min_key_nxt = $signed(cfg_data);
      end else begin
        max_key_nxt = $signed(cfg_data);
      end
    end

    case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        i_nxt = i_r + IW'(1);
        if (i_r == IW'(BUCKETS - 1)) begin
          total_nxt = '0;
          occ_nxt = '0;
          state_nxt = clr_item_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          key_nxt = $signed(in_tdata[31:0]);
          end_nxt = $signed(in_tdata[63:32]);
          res_hit_nxt = 1'b0;
          res_cnt_nxt = '0;
          res_dist_nxt = '0;
          res_wid_nxt = '0;
          if (in_tuser == ewkh_pkg::KIND_CLEAR) begin
            i_nxt = '0;
            clr_item_nxt = 1'b1;
            state_nxt = S_CLR;
          end else if (key_in) begin
            phase_nxt = PH_KEYB;
            state_nxt = S_PREP;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_PREP: begin
        prod_nxt = prod_c;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        q_nxt = '0;
        state_nxt = S_DIV;
        if (bucket_mode) begin
          rem_nxt = SW'(prod_r >> AW);
          num_nxt = prod_r << (NW - AW);
          step_nxt = 6'(AW);
        end else if (BKT_POW2) begin
          // edge division by the bucket count is a plain shift
          q_nxt = SW'(prod_r >> AW);
          state_nxt = S_DONE;
        end else begin
          rem_nxt = SW'(prod_r >> SW);
          num_nxt = prod_r << (NW - SW);
          step_nxt = 6'(SW);
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        rem_nxt = ge ? diff[SW-1:0] : trial[SW-1:0];
        num_nxt = num_r << 1;
        q_nxt = {q_r[SW-2:0], ge};
        step_nxt = step_r - 6'd1;
        if (step_r == 6'd1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        case (phase_r)
          PH_KEYB: begin
            b_nxt = q_r[AW-1:0];
            if (kind_r == ewkh_pkg::KIND_RANGEQ) begin
              if (end_in) begin
                phase_nxt = PH_ENDB;
                state_nxt = S_PREP;
              end else begin
                e_nxt = AW'(BUCKETS - 1);
                i_nxt = IW'(q_r[AW-1:0]);
                acc_nxt = '0;
                pend_nxt = 1'b0;
                state_nxt = S_SUM;
              end
            end else begin
              state_nxt = S_RD;
            end
          end
          PH_ENDB: begin
            e_nxt = q_r[AW-1:0];
            i_nxt = IW'(b_r);
            acc_nxt = '0;
            pend_nxt = 1'b0;
            state_nxt = S_SUM;
          end
          PH_LO: begin
            lo_nxt = q_r;
            phase_nxt = PH_HI;
            state_nxt = S_PREP;
          end
          default: begin
            res_hit_nxt = 1'b1;
            res_wid_nxt = wid;
            res_cnt_nxt = ewkh_pkg::clamp_cnt(64'(cnt_r));
            res_dist_nxt = (64'(wid) < 64'(cnt_r)) ? ewkh_pkg::clamp_cnt(64'(wid))
                                                   : ewkh_pkg::clamp_cnt(64'(cnt_r));
            state_nxt = S_OUT;
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cnt_nxt = c_new;
        if (kind_r == ewkh_pkg::KIND_INSERT) begin
          ram_we = 1'b1;
          ram_waddr = b_r;
          ram_wdata = c_new;
          if (ram_rdata == '0) begin
            occ_nxt = occ_r + IW'(1);
          end
          if (total_r != '1) begin
            total_nxt = total_r + CW'(1);
          end
        end
        phase_nxt = PH_LO;
        state_nxt = S_PREP;
      end
      S_SUM: begin
        ram_raddr = i_r[AW-1:0];
        if (pend_r) begin
          acc_nxt = acc_sum[ewkh_pkg::OCNT_W] ? '1 : acc_sum[ewkh_pkg::OCNT_W-1:0];
        end
        if (i_r <= IW'(e_r)) begin
          i_nxt = i_r + IW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            res_hit_nxt = 1'b1;
            res_cnt_nxt = acc_r;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt = res_hit_r;
          out_cnt_nxt = res_cnt_r;
          out_dist_nxt = res_dist_r;
          out_wid_nxt = res_wid_r;
          out_tot_nxt = ewkh_pkg::clamp_cnt(64'(total_r));
          out_ne_nxt = ewkh_pkg::clamp_ne(64'(occ_r));
          clr_item_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      i_r <= '0;
      clr_item_r <= 1'b0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      total_r <= '0;
      occ_r <= '0;
      min_key_r <= 32'sd0;
      max_key_r <= 32'sh7FFF_FFFF;
      phase_r <= PH_KEYB;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      clr_item_r <= clr_item_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      total_r <= total_nxt;
      occ_r <= occ_nxt;
      min_key_r <= min_key_nxt;
      max_key_r <= max_key_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;     key_r <= key_nxt;       end_r <= end_nxt;
    b_r <= b_nxt;           e_r <= e_nxt;           prod_r <= prod_nxt;
    num_r <= num_nxt;       rem_r <= rem_nxt;       q_r <= q_nxt;
    lo_r <= lo_nxt;         step_r <= step_nxt;     cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;       res_hit_r <= res_hit_nxt; res_cnt_r <= res_cnt_nxt;
    res_dist_r <= res_dist_nxt; res_wid_r <= res_wid_nxt;
    out_hit_r <= out_hit_nxt; out_cnt_r <= out_cnt_nxt; out_dist_r <= out_dist_nxt;
    out_tot_r <= out_tot_nxt; out_wid_r <= out_wid_nxt; out_ne_r <= out_ne_nxt;
  end

  `EWKH_ASSERT(a_one_request, (in_tvalid && in_tready) |=> !in_tready, "request overlap")
  `EWKH_ASSERT(a_occ_bound, occ_r <= IW'(BUCKETS), "occupied count above bucket count")
  `EWKH_ASSERT(a_bucket_q, (state_r == S_DONE && bucket_mode) |-> (q_r < SW'(BUCKETS)), "bucket index")
  `EWKH_ASSERT(a_out_load, (state_r == S_OUT && (!out_valid_r || out_tready)) |=> out_valid_r, "result not loaded")

endmodule

// ===== rtl/ewkh_ram.sv =====
`timescale 1ns / 1ps
module ewkh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/tb_equi_width_key_histogram.sv =====
`timescale 1ns / 1ps
module tb_equi_width_key_histogram;

  localparam int NBKT = 64;
  localparam int SETTLE = 300;   // covers the slowest request with the result held

  typedef struct packed {
    logic                        in_range;
    logic [ewkh_pkg::ONE_W-1:0]  nonempty;
    logic [ewkh_pkg::OCNT_W-1:0] total;
    logic [ewkh_pkg::SPAN_W-1:0] width;
    logic [ewkh_pkg::OCNT_W-1:0] distinct;
    logic [ewkh_pkg::OCNT_W-1:0] count;
  } hist_result_t;

  logic          clk;
  logic          rst_n;
  logic          in_tvalid;
  logic          in_tready;
  logic [1:0]    in_tuser;
  logic [63:0]   in_tdata;
  logic          out_tvalid;
  logic          out_tready;
  logic [0:0]    out_tuser;
  logic [111:0]  out_tdata;
  logic          cfg_valid;
  logic          cfg_ready;
  logic          cfg_addr;
  logic [31:0]   cfg_data;

  // shadow copy of the histogram
  longint signed   lo_key, hi_key;
  longint unsigned bin_cnt[NBKT];
  longint unsigned keys_total;
  int unsigned     used_bins;

  hist_result_t expected_q[$];
  int  fail_cnt;
  bit  no_idle;

  equi_width_key_histogram DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned span_now();
    if (hi_key < lo_key) return 0;
    return longint'(hi_key - lo_key) + 1;
  endfunction

  function automatic int bin_of(longint signed k);
    longint unsigned sp, d;
    sp = span_now();
    if (sp == 0 || k < lo_key || k > hi_key) return NBKT;
    d = k - lo_key;
    return int'(((d + 1) * NBKT - 1) / sp);
  endfunction

  function automatic longint unsigned bin_width(int b);
    longint unsigned sp;
    sp = span_now();
    return ((b + 1) * sp) / NBKT - (b * sp) / NBKT;
  endfunction

  function automatic logic [ewkh_pkg::OCNT_W-1:0] sat24(longint unsigned v);
    return (v > 64'hFF_FFFF) ? '1 : v[ewkh_pkg::OCNT_W-1:0];
  endfunction

  function automatic hist_result_t predict_hist(logic [1:0] kind, logic [31:0] key_bits,
                                                logic [31:0] end_bits);
    hist_result_t    r;
    longint signed   k, ek;
    longint unsigned c, w, sum;
    int              b, e;
    k = longint'($signed(key_bits));
    ek = longint'($signed(end_bits));
    r = '0;
    b = bin_of(k);
    if (kind == ewkh_pkg::KIND_CLEAR) begin
      foreach (bin_cnt[i]) bin_cnt[i] = 0;
      keys_total = 0;
      used_bins = 0;
    end else if (kind == ewkh_pkg::KIND_INSERT || kind == ewkh_pkg::KIND_KEYQ) begin
      if (b < NBKT) begin
        if (kind == ewkh_pkg::KIND_INSERT) begin
          if (bin_cnt[b] == 0) used_bins++;
          if (bin_cnt[b] < 64'hFF_FFFF) bin_cnt[b]++;
          if (keys_total < 64'hFF_FFFF) keys_total++;
        end
        c = bin_cnt[b];
        w = bin_width(b);
        r.in_range = 1'b1;
        r.count = sat24(c);
        r.distinct = sat24(w < c ? w : c);
        r.width = w[ewkh_pkg::SPAN_W-1:0];
      end
    end else begin
      e = bin_of(ek);
      if (e >= NBKT) e = NBKT - 1;
      sum = 0;
      if (b < NBKT) begin
        r.in_range = 1'b1;
        for (int i = b; i <= e; i++) sum += bin_cnt[i];
      end
      r.count = sat24(sum);
    end
    r.total = sat24(keys_total);
    r.nonempty = (used_bins > 127) ? '1 : used_bins[ewkh_pkg::ONE_W-1:0];
    return r;
  endfunction

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(99) < 34);
  endfunction

  task automatic send_req(logic [1:0] kind, logic [31:0] key_bits, logic [31:0] end_bits);
    bit hs;
    while (take_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {end_bits, key_bits};
    do begin
      @(negedge clk);
      hs = in_tready;
      @(posedge clk);
    end while (!hs);
    expected_q.push_back(predict_hist(kind, key_bits, end_bits));
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic idx, logic [31:0] val);
    bit hs;
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
    cfg_valid <= 1'b0;
    if (idx == ewkh_pkg::CFG_MIN_KEY) lo_key = longint'($signed(val));
    else hi_key = longint'($signed(val));
  endtask

  task automatic set_range(logic [31:0] lo, logic [31:0] hi);
    write_reg(ewkh_pkg::CFG_MIN_KEY, lo);
    write_reg(ewkh_pkg::CFG_MAX_KEY, hi);
  endtask

  // key inside the current range most of the time, anything otherwise
  function automatic logic [31:0] pick_key();
    longint unsigned sp, off;
    sp = span_now();
    if (sp == 0 || $urandom_range(9) == 0) return $urandom;
    off = {$urandom, $urandom} % sp;
    return 32'(lo_key + longint'(off));
  endfunction

  // result side: random backpressure, check on each accepted result
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= no_idle || ($urandom_range(99) >= 34);
  end

  always @(negedge clk) begin
    hist_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata};
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.in_range !== exp_r.in_range) begin
          $error("in_range exp %0d got %0d", exp_r.in_range, got.in_range); fail_cnt++;
        end
        if (got.count !== exp_r.count) begin
          $error("count exp %0d got %0d", exp_r.count, got.count); fail_cnt++;
        end
        if (got.distinct !== exp_r.distinct) begin
          $error("distinct_values exp %0d got %0d", exp_r.distinct, got.distinct);
          fail_cnt++;
        end
        if (got.width !== exp_r.width) begin
          $error("bucket_width exp %0d got %0d", exp_r.width, got.width); fail_cnt++;
        end
        if (got.total !== exp_r.total) begin
          $error("total_keys exp %0d got %0d", exp_r.total, got.total); fail_cnt++;
        end
        if (got.nonempty !== exp_r.nonempty) begin
          $error("nonempty_buckets exp %0d got %0d", exp_r.nonempty, got.nonempty);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_default_range();
    send_req(ewkh_pkg::KIND_CLEAR, $urandom, $urandom);
    send_req(ewkh_pkg::KIND_INSERT, 32'h0000_0000, 32'h0);
    send_req(ewkh_pkg::KIND_INSERT, 32'h7FFF_FFFF, 32'h0);
    send_req(ewkh_pkg::KIND_INSERT, 32'h8000_0000, 32'h0);   // below range, no effect
    send_req(ewkh_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_req(ewkh_pkg::KIND_KEYQ, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(ewkh_pkg::KIND_KEYQ, 32'h7FFF_FFFF, 32'h0);
    send_req(ewkh_pkg::KIND_KEYQ, 32'h8000_0000, 32'h0);
    send_req(ewkh_pkg::KIND_RANGEQ, 32'h0000_0000, 32'h7FFF_FFFF);
    send_req(ewkh_pkg::KIND_RANGEQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF);  // start outside
    send_req(ewkh_pkg::KIND_RANGEQ, 32'h0000_0000, 32'h8000_0000);  // end below
    send_req(ewkh_pkg::KIND_RANGEQ, 32'h7FFF_FFFF, 32'h0000_0000);  // end before start
  endtask

  task automatic test_narrow_range();
    set_range(32'hFFFF_FFF6, 32'd20);   // span smaller than the bucket count
    send_req(ewkh_pkg::KIND_INSERT, 32'hFFFF_FFF6, 32'h0);
    send_req(ewkh_pkg::KIND_INSERT, 32'd20, 32'h0);
    send_req(ewkh_pkg::KIND_INSERT, 32'd21, 32'h0);
    send_req(ewkh_pkg::KIND_KEYQ, 32'd3, 32'h0);
    send_req(ewkh_pkg::KIND_RANGEQ, 32'hFFFF_FFF6, 32'd5000);       // end above
    send_req(ewkh_pkg::KIND_RANGEQ, 32'd0, 32'd20);
  endtask

  task automatic test_inverted_range();
    set_range(32'd100, 32'd50);
    send_req(ewkh_pkg::KIND_INSERT, 32'd75, 32'h0);
    send_req(ewkh_pkg::KIND_KEYQ, 32'd75, 32'h0);
    send_req(ewkh_pkg::KIND_RANGEQ, 32'd50, 32'd100);
  endtask

  task automatic test_random(int n);
    logic [1:0] kind;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      kind = (r < 3) ? ewkh_pkg::KIND_CLEAR : (r < 60) ? ewkh_pkg::KIND_INSERT :
             (r < 80) ? ewkh_pkg::KIND_KEYQ : ewkh_pkg::KIND_RANGEQ;
      send_req(kind, pick_key(), pick_key());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_addr = ewkh_pkg::CFG_MIN_KEY;
    cfg_data = '0;
    no_idle = 1'b0;
    fail_cnt = 0;
    lo_key = 0;
    hi_key = 64'sd2147483647;
    foreach (bin_cnt[i]) bin_cnt[i] = 0;
    keys_total = 0;
    used_bins = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_range();
    test_narrow_range();
    test_inverted_range();

    set_range(32'h8000_0000, 32'h7FFF_FFFF);   // full key space
    test_random(120);
    no_idle = 1'b1;
    test_random(80);
    no_idle = 1'b0;
    set_range(32'hFFFF_FF00, 32'd1000);
    test_random(120);
    set_range(32'd5, 32'd5);                   // single key
    test_random(30);
    set_range(32'h8000_0000, 32'h8000_0030);
    test_random(100);
    set_range(32'h7FFF_FF00, 32'h7FFF_FFFF);
    test_random(60);

    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
